FILE: sv/uble_pkg.sv
// Shared types and character constants for the uuencode / base64 line encoder.
package uble_pkg;

    // One unit of work passed from the front end to the back end.
    typedef struct packed {
        logic       is_end;
        logic [1:0] nbytes;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
    } job_t;

    localparam logic [7:0] CHAR_NL   = 8'h0A;
    localparam logic [7:0] CHAR_PAD  = 8'h3D;
    localparam logic [7:0] CHAR_BIAS = 8'h20;

endpackage

FILE: sv/uble_if.sv
// Valid/ready channel interfaces for the encoder input and output.
interface uble_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] data_byte;

    modport source (output valid, output cmd, output data_byte, input ready);
    modport sink (input valid, input cmd, input data_byte, output ready);
endinterface

interface uble_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last_of_run;

    modport source (output valid, output out_char, output last_of_run, input ready);
    modport sink (input valid, input out_char, input last_of_run, output ready);
endinterface

FILE: sv/uble_front.sv
// Front end: gathers input bytes into groups and issues group and end jobs.
module uble_front (
    input  logic            clk,
    input  logic            rst_n,
    uble_in_if.sink         in_ch,
    input  logic            q_full,
    output logic            push,
    output uble_pkg::job_t  push_job
);
    import uble_pkg::*;

    logic [7:0] held0_reg, held0_next;
    logic [7:0] held1_reg, held1_next;
    logic [1:0] fill_reg, fill_next;
    logic       accept;

    // A transfer is taken whenever the queue has room for a possible job.
    assign in_ch.ready = !q_full;
    assign accept      = in_ch.valid && !q_full;

    // Classify the item: hold a byte, complete a group, or end the stream.
    always_comb
    begin
        held0_next = held0_reg;
        held1_next = held1_reg;
        fill_next  = fill_reg;
        push       = 1'b0;
        push_job   = '{is_end: 1'b0, nbytes: 2'd3, b0: held0_reg, b1: held1_reg,
                       b2: in_ch.data_byte};
        if (accept)
        begin
            if (!in_ch.cmd)
            begin
                if (fill_reg < 2'd2)
                begin
                    if (fill_reg == 2'd0)
                    begin
                        held0_next = in_ch.data_byte;
                    end
                    else
                    begin
                        held1_next = in_ch.data_byte;
                    end
                    fill_next = fill_reg + 2'd1;
                end
                else
                begin
                    push       = 1'b1;
                    fill_next  = 2'd0;
                    held0_next = 8'h00;
                    held1_next = 8'h00;
                end
            end
            else
            begin
                push       = 1'b1;
                push_job   = '{is_end: 1'b1, nbytes: fill_reg, b0: held0_reg,
                               b1: held1_reg, b2: 8'h00};
                fill_next  = 2'd0;
                held0_next = 8'h00;
                held1_next = 8'h00;
            end
        end
    end

    // Group gathering state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held0_reg <= 8'h00;
            held1_reg <= 8'h00;
            fill_reg  <= 2'd0;
        end
        else
        begin
            held0_reg <= held0_next;
            held1_reg <= held1_next;
            fill_reg  <= fill_next;
        end
    end

endmodule

FILE: sv/uble_queue.sv
// Two-entry job queue between the front end and the back end.
module uble_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  uble_pkg::job_t  push_job,
    input  logic            pop,
    output logic            q_valid,
    output logic            q_full,
    output uble_pkg::job_t  q_job
);
    import uble_pkg::*;

    job_t       entries_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push;
    logic       do_pop;

    assign q_valid = (count_reg != 2'd0);
    assign q_full  = (count_reg == 2'd2);
    assign q_job   = entries_reg[rd_ptr_reg];
    assign do_push = push && !q_full;
    assign do_pop  = pop && q_valid;

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Job storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

FILE: sv/uble_back.sv
// Back end: encodes jobs, keeps line state and the line store, drives characters.
module uble_back #(
    parameter int BASE64_LINE_CHARS = 72,
    parameter int UU_LINE_CHARS     = 60
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            mode,
    input  logic            q_valid,
    input  uble_pkg::job_t  q_job,
    output logic            pop,
    uble_out_if.source      out_ch
);
    import uble_pkg::*;

    localparam int IDX_W = $clog2(UU_LINE_CHARS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_B64_CHAR,
        ST_B64_BRK,
        ST_END_NL,
        ST_UU_WR,
        ST_UU_LEN,
        ST_UU_DATA,
        ST_UU_NL
    } state_t;

    state_t     state_reg, state_next;
    job_t       job_reg, job_next;
    logic [1:0] idx_reg, idx_next;
    logic [6:0] b64_cnt_reg, b64_cnt_next;
    logic [5:0] uu_fill_reg, uu_fill_next;
    logic [5:0] uu_bytes_reg, uu_bytes_next;
    logic [5:0] data_idx_reg, data_idx_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_char_reg, out_char_next;
    logic       out_last_reg, out_last_next;

    logic [5:0] uu_store_reg [UU_LINE_CHARS];
    logic [5:0] rd_data_reg;

    logic             mem_we;
    logic [IDX_W-1:0] mem_wa;
    logic [5:0]       mem_wd;
    logic             mem_re;
    logic [IDX_W-1:0] mem_ra;

    logic       slot_free;
    logic [5:0] sextet;
    logic [7:0] cnt4;
    logic       wr_ok;
    logic [5:0] fill_after;
    logic [5:0] nxt_idx;

    // Maps a 6-bit value to its base64 alphabet character.
    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] w;
        w = {2'b00, v};
        if (v < 6'd26)
        begin
            return 8'h41 + w;
        end
        else if (v < 6'd52)
        begin
            return 8'h61 + w - 8'd26;
        end
        else if (v < 6'd62)
        begin
            return 8'h30 + w - 8'd52;
        end
        else if (v == 6'd62)
        begin
            return 8'h2B;
        end
        return 8'h2F;
    endfunction

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.out_char    = out_char_reg;
    assign out_ch.last_of_run = out_last_reg;

    // The output register can take a new character when empty or being drained.
    assign slot_free = !out_valid_reg || out_ch.ready;

    // Split the current group into its four 6-bit values.
    always_comb
    begin
        case (idx_reg)
            2'd0:    sextet = job_reg.b0[7:2];
            2'd1:    sextet = {job_reg.b0[1:0], job_reg.b1[7:4]};
            2'd2:    sextet = {job_reg.b1[3:0], job_reg.b2[7:6]};
            default: sextet = job_reg.b2[5:0];
        endcase
    end

    assign cnt4       = {1'b0, b64_cnt_reg} + 8'd4;
    assign wr_ok      = (uu_fill_reg < 6'(UU_LINE_CHARS));
    assign fill_after = uu_fill_reg + {5'd0, wr_ok};
    assign nxt_idx    = data_idx_reg + 6'd1;

    // Job sequencer.
    always_comb
    begin
        state_next     = state_reg;
        job_next       = job_reg;
        idx_next       = idx_reg;
        b64_cnt_next   = b64_cnt_reg;
        uu_fill_next   = uu_fill_reg;
        uu_bytes_next  = uu_bytes_reg;
        data_idx_next  = data_idx_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        pop            = 1'b0;
        mem_we         = 1'b0;
        mem_wa         = uu_fill_reg[IDX_W-1:0];
        mem_wd         = sextet;
        mem_re         = 1'b0;
        mem_ra         = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    pop      = 1'b1;
                    job_next = q_job;
                    idx_next = 2'd0;
                    if (mode)
                    begin
                        state_next = (q_job.nbytes == 2'd0) ? ST_END_NL : ST_B64_CHAR;
                    end
                    else
                    begin
                        state_next = (q_job.nbytes == 2'd0) ? ST_UU_LEN : ST_UU_WR;
                    end
                end
            end

            ST_B64_CHAR:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_last_next  = 1'b0;
                    if ({1'b0, job_reg.nbytes} < {1'b0, idx_reg})
                    begin
                        out_char_next = CHAR_PAD;
                    end
                    else
                    begin
                        out_char_next = b64_char(sextet);
                    end
                    if (idx_reg == 2'd3)
                    begin
                        if ((cnt4 + 8'd3) >= 8'(BASE64_LINE_CHARS))
                        begin
                            b64_cnt_next = 7'd0;
                            state_next   = ST_B64_BRK;
                        end
                        else
                        begin
                            b64_cnt_next = cnt4[6:0];
                            if (job_reg.is_end)
                            begin
                                state_next = ST_END_NL;
                            end
                            else
                            begin
                                out_last_next = 1'b1;
                                state_next    = ST_IDLE;
                            end
                        end
                    end
                    else
                    begin
                        idx_next = idx_reg + 2'd1;
                    end
                end
            end

            ST_B64_BRK:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = CHAR_NL;
                    out_last_next  = !job_reg.is_end;
                    state_next     = job_reg.is_end ? ST_END_NL : ST_IDLE;
                end
            end

            ST_END_NL:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = CHAR_NL;
                    out_last_next  = 1'b1;
                    b64_cnt_next   = 7'd0;
                    uu_fill_next   = 6'd0;
                    uu_bytes_next  = 6'd0;
                    state_next     = ST_IDLE;
                end
            end

            ST_UU_WR:
            begin
                // One line store write per cycle; a full store drops the value.
                mem_we       = wr_ok;
                uu_fill_next = fill_after;
                if (idx_reg == job_reg.nbytes)
                begin
                    uu_bytes_next = uu_bytes_reg + {4'd0, job_reg.nbytes};
                    if (job_reg.is_end)
                    begin
                        state_next = ST_UU_LEN;
                    end
                    else if (({1'b0, fill_after} + 7'd3) >= 7'(UU_LINE_CHARS))
                    begin
                        state_next = ST_UU_LEN;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    idx_next = idx_reg + 2'd1;
                end
            end

            ST_UU_LEN:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = {2'b00, uu_bytes_reg} + CHAR_BIAS;
                    out_last_next  = 1'b0;
                    data_idx_next  = 6'd0;
                    if (uu_fill_reg != 6'd0)
                    begin
                        mem_re     = 1'b1;
                        state_next = ST_UU_DATA;
                    end
                    else
                    begin
                        state_next = ST_UU_NL;
                    end
                end
            end

            ST_UU_DATA:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = {2'b00, rd_data_reg} + CHAR_BIAS;
                    out_last_next  = 1'b0;
                    if (nxt_idx < uu_fill_reg)
                    begin
                        mem_re        = 1'b1;
                        mem_ra        = nxt_idx[IDX_W-1:0];
                        data_idx_next = nxt_idx;
                    end
                    else
                    begin
                        state_next = ST_UU_NL;
                    end
                end
            end

            ST_UU_NL:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = CHAR_NL;
                    out_last_next  = 1'b1;
                    uu_fill_next   = 6'd0;
                    uu_bytes_next  = 6'd0;
                    if (job_reg.is_end)
                    begin
                        b64_cnt_next = 7'd0;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, counters and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= 2'd0;
            b64_cnt_reg   <= 7'd0;
            uu_fill_reg   <= 6'd0;
            uu_bytes_reg  <= 6'd0;
            data_idx_reg  <= 6'd0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            b64_cnt_reg   <= b64_cnt_next;
            uu_fill_reg   <= uu_fill_next;
            uu_bytes_reg  <= uu_bytes_next;
            data_idx_reg  <= data_idx_next;
            out_valid_reg <= out_valid_next;
            out_last_reg  <= out_last_next;
        end
    end

    // Payload registers without reset.
    always_ff @(posedge clk)
    begin
        job_reg      <= job_next;
        out_char_reg <= out_char_next;
    end

    // Line store with one write port and a registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            uu_store_reg[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rd_data_reg <= uu_store_reg[mem_ra];
        end
    end

endmodule

FILE: sv/uuencode_base64_line_encoder.sv
// Top level of the streaming uuencode / base64 line encoder.
//
// Input channel in_ch carries one item per transfer: cmd 0 with a raw
// data_byte, or cmd 1 to end the stream and flush the partial group and line.
// Output channel out_ch carries one ASCII character per transfer, with
// last_of_run marking the final character caused by an input item.
// cfg_wr_en/cfg_wr_data set the encoding mode (0 uuencode, 1 base64); write it
// only while the encoder is idle.
// The front end takes one transfer per cycle while its two-entry job queue has
// room. The back end takes a new job only while idle and emits at most one
// character per cycle into an output register while it is free: four per group
// in base64 (five with a line break); in uuencode a group makes 2 to 4 line store
// writes, and a full line gives a length character, fill data characters and a newline.
// The first character of a group follows the completing byte through the job
// queue, the job register and the output register. When the receiver stalls,
// the output register holds, the back end waits, and the queue fills until
// in_ch.ready drops.
// Reset clears the mode to uuencode, all counters and the queue; the line store
// needs no clearing since only entries of the current line are read.
module uuencode_base64_line_encoder #(
    parameter int BASE64_LINE_CHARS = 72,
    parameter int UU_LINE_CHARS     = 60
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    uble_in_if.sink     in_ch,
    uble_out_if.source  out_ch
);
    import uble_pkg::*;

    logic mode_reg;
    logic push;
    job_t push_job;
    logic pop;
    logic q_valid;
    logic q_full;
    job_t q_job;

    // Encoding mode register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            mode_reg <= cfg_wr_data;
        end
    end

    uble_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .q_full   (q_full),
        .push     (push),
        .push_job (push_job)
    );

    uble_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_full   (q_full),
        .q_job    (q_job)
    );

    uble_back #(
        .BASE64_LINE_CHARS (BASE64_LINE_CHARS),
        .UU_LINE_CHARS     (UU_LINE_CHARS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .mode    (mode_reg),
        .q_valid (q_valid),
        .q_job   (q_job),
        .pop     (pop),
        .out_ch  (out_ch)
    );

endmodule
